>>> src/edfs_pkg.sv
// Types and constants for the earliest-deadline-first task scheduler.
// Used by edfs_cell and edf_periodic_task_scheduler; depends on nothing.
package edfs_pkg;

  localparam int MaxTasksDflt = 8;
  // Slot index width wide enough for the largest supported slot count
  localparam int TaskIdxW     = 5;
  localparam int NumTasksW    = 4;
  localparam logic [NumTasksW-1:0] NumTasksRst = NumTasksW'(1);

  typedef enum logic {
    OpLoad = 1'b0,
    OpTick = 1'b1
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [2:0]  task_index;
    logic [15:0] burst_time;
    logic [15:0] relative_deadline;
    logic [15:0] period;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  running_task;
    logic        cpu_idle;
    logic [31:0] tick_time;
  } out_item_t;

  // Best candidate so far, passed from cell to cell during a scan
  typedef struct packed {
    logic                token;
    logic                found;
    logic [TaskIdxW-1:0] idx;
    logic [32:0]         dl;
  } scan_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic                restart;
    logic                release_en;
    logic                commit;
    logic                found;
    logic [TaskIdxW-1:0] idx;
  } cell_ctrl_t;

endpackage

>>> src/edfs_cell.sv
// One task slot of the scheduler: parameter tables, release and run state,
// and one stage of the deadline scan chain. Depends on edfs_pkg.
module edfs_cell #(
  parameter int CellIdx = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  active_i,
  input  logic                  load_en_i,
  input  edfs_pkg::in_item_t    item_i,
  input  edfs_pkg::cell_ctrl_t  ctrl_i,
  input  logic [31:0]           time_i,
  input  edfs_pkg::scan_t       scan_i,
  output edfs_pkg::scan_t       scan_o
);

  localparam logic [edfs_pkg::TaskIdxW-1:0] OwnIdx = edfs_pkg::TaskIdxW'(CellIdx);

  logic [15:0]     burst_q, deadline_q, period_q;
  logic [15:0]     rem_q, rem_d;
  logic [32:0]     absdl_q, absdl_d;
  logic [15:0]     phase_q, phase_d;
  logic [16:0]     phase_next;
  logic            take;
  edfs_pkg::scan_t scan_q, scan_d;

  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      burst_q    <= item_i.burst_time;
      deadline_q <= item_i.relative_deadline;
      period_q   <= item_i.period;
    end
  end

  assign phase_next = {1'b0, phase_q} + 17'd1;

  always_comb begin
    rem_d   = rem_q;
    absdl_d = absdl_q;
    phase_d = phase_q;
    if (ctrl_i.restart) begin
      rem_d   = '0;
      absdl_d = '0;
      phase_d = '0;
    end else if (ctrl_i.release_en && active_i && phase_q == '0) begin
      rem_d   = burst_q;
      absdl_d = {1'b0, time_i} + {17'd0, deadline_q};
    end else if (ctrl_i.commit && active_i) begin
      // advance phase, wrap at the period; a zero period behaves as one
      phase_d = (phase_next >= {1'b0, period_q}) ? 16'd0 : phase_next[15:0];
      if (ctrl_i.found && ctrl_i.idx == OwnIdx) begin
        rem_d = rem_q - 16'd1;
      end
    end
  end

  assign take = scan_i.token && active_i && rem_q != '0 &&
                (!scan_i.found || absdl_q < scan_i.dl);

  always_comb begin
    scan_d = scan_i;
    if (take) begin
      scan_d.found = 1'b1;
      scan_d.idx   = OwnIdx;
      scan_d.dl    = absdl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      absdl_q <= '0;
      phase_q <= '0;
      scan_q  <= '0;
    end else begin
      rem_q   <= rem_d;
      absdl_q <= absdl_d;
      phase_q <= phase_d;
      scan_q  <= scan_d;
    end
  end

  assign scan_o = scan_q;

endmodule

>>> src/edf_periodic_task_scheduler.sv
// Earliest-deadline-first scheduler for periodic tasks, built as a row of task cells.
// Depends on edfs_pkg and edfs_cell.
//
// A load item writes one slot's burst, deadline and period and restarts the run; it
// gives no result. A tick item releases due tasks, then a scan token walks the row of
// MaxTasks cells, one cell per cycle, carrying the earliest deadline seen so far; the
// winner is charged one tick and the result is registered. A tick passes the launch,
// scan and commit states; the commit waits while the output holds an untaken result.
// Write num_tasks only while the block is idle.
module edf_periodic_task_scheduler #(
  parameter int MaxTasks = edfs_pkg::MaxTasksDflt
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  edfs_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output edfs_pkg::out_item_t               out_item_o,
  input  logic                              cfg_we_i,
  input  logic [edfs_pkg::NumTasksW-1:0]    cfg_wdata_i
);

  typedef enum logic [1:0] {
    StIdle,
    StLaunch,
    StScan,
    StCommit
  } state_e;

  state_e                          state_q;
  logic [edfs_pkg::NumTasksW-1:0]  num_tasks_q;
  logic [31:0]                     time_q;
  logic                            out_valid_q;
  edfs_pkg::out_item_t             out_item_q;
  edfs_pkg::scan_t                 res_q;
  logic                            accept, out_free;
  edfs_pkg::cell_ctrl_t            ctrl;
  edfs_pkg::scan_t                 chain [MaxTasks+1];

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    ctrl            = '0;
    ctrl.restart    = accept && in_item_i.op == edfs_pkg::OpLoad;
    ctrl.release_en = accept && in_item_i.op == edfs_pkg::OpTick;
    ctrl.commit     = (state_q == StCommit) && out_free;
    ctrl.found      = res_q.found;
    ctrl.idx        = res_q.idx;
  end

  assign chain[0] = '{token: (state_q == StLaunch), found: 1'b0, idx: '0, dl: '0};

  for (genvar g = 0; g < MaxTasks; g++) begin : g_cell
    edfs_cell #(
      .CellIdx(g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .active_i  (32'(num_tasks_q) > g),
      .load_en_i (ctrl.restart && 32'(in_item_i.task_index) == g),
      .item_i    (in_item_i),
      .ctrl_i    (ctrl),
      .time_i    (time_q),
      .scan_i    (chain[g]),
      .scan_o    (chain[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      num_tasks_q <= edfs_pkg::NumTasksRst;
      time_q      <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
      res_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        num_tasks_q <= cfg_wdata_i;
      end
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (ctrl.restart) begin
            time_q <= '0;
          end else if (ctrl.release_en) begin
            state_q <= StLaunch;
          end
        end
        StLaunch: begin
          state_q <= StScan;
        end
        StScan: begin
          // hold the winner once the token leaves the last cell
          if (chain[MaxTasks].token) begin
            res_q   <= chain[MaxTasks];
            state_q <= StCommit;
          end
        end
        StCommit: begin
          if (out_free) begin
            out_item_q.running_task <= res_q.found ? res_q.idx[2:0] : 3'd0;
            out_item_q.cpu_idle     <= !res_q.found;
            out_item_q.tick_time    <= time_q;
            out_valid_q             <= 1'b1;
            time_q                  <= time_q + 32'd1;
            state_q                 <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[MaxTasks].token |-> state_q == StScan)
    else $error("scan token left the chain outside the scan phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.commit |-> (!out_valid_q || out_ready_i))
    else $error("commit while the output register is occupied");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.cpu_idle |-> out_item_o.running_task == 3'd0)
    else $error("idle result names a task");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.release_en |=> state_q == StLaunch)
    else $error("tick transfer did not launch a scan");

endmodule
